// File: rtl/lrc_pkg.sv
// Shared constants and types for the linear range calibrator.
package lrc_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ProdW   = 2 * DataW;
  localparam int unsigned QuoW    = 36;
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [DataW-1:0] RawLowRst  = 32'sd0;
  localparam logic signed [DataW-1:0] RawHighRst = 32'sd65535;
  localparam logic signed [DataW-1:0] CalLowRst  = 32'sd0;
  localparam logic signed [DataW-1:0] CalHighRst = 32'sd65535;

  localparam logic signed [DataW-1:0] ValMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] ValMin = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    RegRawLow  = 3'd0,
    RegRawHigh = 3'd1,
    RegCalLow  = 3'd2,
    RegCalHigh = 3'd3,
    RegClampEn = 3'd4
  } lrc_reg_e;

  // One step of the restoring divider: partial remainder plus a shift word that
  // holds the unused dividend bits on top and the quotient bits found so far below.
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [DataW-1:0] rem;
    logic [QuoW-1:0]  nq;
  } lrc_div_t;

endpackage

// File: rtl/lrc_div_stage.sv
// One registered step of the restoring divider: one quotient bit per stage.
module lrc_div_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [lrc_pkg::DataW-1:0]   den_i,
  input  logic                        vld_i,
  input  lrc_pkg::lrc_div_t           stg_i,
  output logic                        vld_o,
  output lrc_pkg::lrc_div_t           stg_o
);
  import lrc_pkg::*;

  logic [DataW:0] trial;
  logic [DataW:0] diff;
  logic           fits;
  lrc_div_t       stg_d;
  lrc_div_t       stg_q;
  logic           vld_q;

  always_comb begin
    trial     = {stg_i.rem, stg_i.nq[QuoW-1]};
    diff      = trial - {1'b0, den_i};
    fits      = (trial >= {1'b0, den_i});
    stg_d.neg = stg_i.neg;
    stg_d.ovf = stg_i.ovf;
    // remainder stays below the divisor, so it fits in DataW bits
    stg_d.rem = fits ? diff[DataW-1:0] : trial[DataW-1:0];
    stg_d.nq  = {stg_i.nq[QuoW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q <= stg_d;
    end
  end

  assign vld_o = vld_q;
  assign stg_o = stg_q;

endmodule

// File: rtl/linear_range_calibrator_unit.sv
// Linear range calibrator: maps a raw sample from [raw_low, raw_high] onto
// [cal_low, cal_high] with an exact quotient, round half away from zero,
// 32-bit saturation and optional clamping. Takes one item per clock and keeps
// that rate while out_stall_i is low; a result passes through the operand and
// multiply stages, the 36-step restoring divider (one quotient bit per stage)
// and the rounding stages before it shows on out_valid_o. A two-entry output
// buffer lets the pipeline keep accepting items while a result waits;
// in_stall_o rises only when both entries are full.
// The configuration port never stalls; registers are meant to change only
// while no item is in flight. A zero raw span gives 0 with span_zero set.
module linear_range_calibrator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lrc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [lrc_pkg::DataW-1:0]         cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [lrc_pkg::DataW-1:0]  raw_sample_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [lrc_pkg::DataW-1:0]  cal_value_o,
  output logic                              span_zero_o,
  output logic                              saturated_o
);
  import lrc_pkg::*;

  localparam int unsigned HiW = ProdW - QuoW;
  localparam logic [QuoW:0] QMagLim = {{(QuoW-34){1'b0}}, 1'b1, 34'b0};

  // configuration registers
  logic signed [DataW-1:0] raw_low_q, raw_high_q, cal_low_q, cal_high_q;
  logic                    clamp_en_q;

  // values derived from configuration
  logic [DataW:0]   den_w, cspan_w;
  logic [DataW-1:0] den_mag_q, bmag_q;
  logic             den_neg_q, bneg_q, span_zero_q;

  logic en;

  // operand stages
  logic             s0_vld_q, s1_vld_q, s2_vld_q;
  logic [DataW:0]   s0_a_q;
  logic [DataW-1:0] s1_amag_q;
  logic             s1_aneg_q;
  logic [ProdW-1:0] s2_prod_q;
  logic             s2_neg_q;
  logic [DataW:0]   s0_a_d;
  logic [DataW:0]   s1_amag_w;
  logic [ProdW-1:0] s2_prod_d;

  // divider chain
  logic     div_vld [QuoW+1];
  lrc_div_t div_stg [QuoW+1];
  lrc_div_t div_init_d;

  // rounding and limiting stages
  logic                 s4_vld_q, s5_vld_q, s6_vld_q, s7_vld_q, s8_vld_q, s9_vld_q;
  logic [QuoW:0]        s4_qmag_q, s4_qmag_d;
  logic [DataW-1:0]     s4_r_q, s4_r_d;
  logic                 s4_qneg_q, s4_ovf_q, s4_adj;
  logic signed [QuoW-1:0] s5_q_q, s5_q_d;
  logic                 s5_big_q, s5_qneg_q, s5_ge_q, s5_gt_q, s5_rnz_q;
  logic [DataW:0]       s5_twice;
  logic signed [QuoW:0] s6_n_q, s6_n_d;
  logic                 s6_big_q, s6_qneg_q, s6_ge_q, s6_gt_q, s6_rnz_q;
  logic signed [QuoW:0] s7_n_q, s7_n_d;
  logic                 s7_big_q, s7_qneg_q, s7_inc;
  logic signed [DataW-1:0] s8_res_q, s8_res_d;
  logic                 s8_sat_q, s8_sat_d;
  logic                 s7_ovf_pos, s7_ovf_neg;
  logic signed [DataW-1:0] s9_res_q, s9_res_d;
  logic                 s9_sat_q, s9_sat_d, s9_sz_q;

  // output register and skid entry
  logic                    out_vld_q, sk_vld_q, take;
  logic signed [DataW-1:0] out_cal_q, sk_cal_q;
  logic                    out_sz_q, out_sat_q, sk_sz_q, sk_sat_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_low_q  <= RawLowRst;
      raw_high_q <= RawHighRst;
      cal_low_q  <= CalLowRst;
      cal_high_q <= CalHighRst;
      clamp_en_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lrc_reg_e'(cfg_index_i))
        RegRawLow:  raw_low_q  <= cfg_data_i;
        RegRawHigh: raw_high_q <= cfg_data_i;
        RegCalLow:  cal_low_q  <= cfg_data_i;
        RegCalHigh: cal_high_q <= cfg_data_i;
        RegClampEn: clamp_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    den_w   = {raw_high_q[DataW-1], raw_high_q} - {raw_low_q[DataW-1], raw_low_q};
    cspan_w = {cal_high_q[DataW-1], cal_high_q} - {cal_low_q[DataW-1], cal_low_q};
  end

  always_ff @(posedge clk_i) begin
    den_neg_q   <= den_w[DataW];
    den_mag_q   <= den_w[DataW] ? DataW'(-den_w) : den_w[DataW-1:0];
    bneg_q      <= cspan_w[DataW];
    bmag_q      <= cspan_w[DataW] ? DataW'(-cspan_w) : cspan_w[DataW-1:0];
    span_zero_q <= (raw_low_q == raw_high_q);
  end

  // whole pipeline moves unless the skid entry is occupied
  assign en         = !sk_vld_q;
  assign in_stall_o = !en;

  always_comb begin
    s0_a_d    = {raw_sample_i[DataW-1], raw_sample_i} - {raw_low_q[DataW-1], raw_low_q};
    s1_amag_w = s0_a_q[DataW] ? -s0_a_q : s0_a_q;
    s2_prod_d = s1_amag_q * bmag_q;
  end

  always_comb begin
    div_init_d.neg = s2_neg_q;
    div_init_d.ovf = ({{(DataW-HiW){1'b0}}, s2_prod_q[ProdW-1:QuoW]} >= den_mag_q);
    div_init_d.rem = {{(DataW-HiW){1'b0}}, s2_prod_q[ProdW-1:QuoW]};
    div_init_d.nq  = s2_prod_q[QuoW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q   <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      div_vld[0] <= 1'b0;
    end else if (en) begin
      s0_vld_q   <= in_valid_i;
      s1_vld_q   <= s0_vld_q;
      s2_vld_q   <= s1_vld_q;
      div_vld[0] <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_a_q     <= s0_a_d;
      s1_amag_q  <= s1_amag_w[DataW-1:0];
      s1_aneg_q  <= s0_a_q[DataW];
      s2_prod_q  <= s2_prod_d;
      s2_neg_q   <= s1_aneg_q ^ bneg_q ^ den_neg_q;
      div_stg[0] <= div_init_d;
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    lrc_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .den_i  (den_mag_q),
      .vld_i  (div_vld[k]),
      .stg_i  (div_stg[k]),
      .vld_o  (div_vld[k+1]),
      .stg_o  (div_stg[k+1])
    );
  end

  always_comb begin
    // floor quotient: a negative quotient with a remainder rounds down
    s4_adj    = div_stg[QuoW].neg && (div_stg[QuoW].rem != '0);
    s4_qmag_d = {1'b0, div_stg[QuoW].nq} + (QuoW+1)'(s4_adj);
    s4_r_d    = s4_adj ? (den_mag_q - div_stg[QuoW].rem) : div_stg[QuoW].rem;

    s5_q_d    = s4_qneg_q ? -$signed(s4_qmag_q[QuoW-1:0]) : $signed(s4_qmag_q[QuoW-1:0]);
    s5_twice  = {s4_r_q, 1'b0};

    s6_n_d    = $signed({s5_q_q[QuoW-1], s5_q_q})
              + $signed({{(QuoW+1-DataW){cal_low_q[DataW-1]}}, cal_low_q});

    // halves go up for non-negative sums, down for negative ones
    s7_inc    = s6_rnz_q && (s6_n_q[QuoW] ? s6_gt_q : s6_ge_q);
    s7_n_d    = s6_n_q + $signed((QuoW+1)'(s7_inc));

    s7_ovf_pos = !s7_n_q[QuoW] && (|s7_n_q[QuoW-1:DataW-1]);
    s7_ovf_neg =  s7_n_q[QuoW] && !(&s7_n_q[QuoW-1:DataW-1]);
    priority if (s7_big_q) begin
      s8_sat_d = 1'b1;
      s8_res_d = s7_qneg_q ? ValMin : ValMax;
    end else if (s7_ovf_pos) begin
      s8_sat_d = 1'b1;
      s8_res_d = ValMax;
    end else if (s7_ovf_neg) begin
      s8_sat_d = 1'b1;
      s8_res_d = ValMin;
    end else begin
      s8_sat_d = 1'b0;
      s8_res_d = s7_n_q[DataW-1:0];
    end

    s9_res_d = s8_res_q;
    if (clamp_en_q) begin
      if (cal_low_q < cal_high_q) begin
        if (s8_res_q < cal_low_q) begin
          s9_res_d = cal_low_q;
        end else if (s8_res_q > cal_high_q) begin
          s9_res_d = cal_high_q;
        end
      end else begin
        if (s8_res_q > cal_low_q) begin
          s9_res_d = cal_low_q;
        end else if (s8_res_q < cal_high_q) begin
          s9_res_d = cal_high_q;
        end
      end
    end
    s9_sat_d = s8_sat_q;
    if (span_zero_q) begin
      s9_res_d = '0;
      s9_sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      s9_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= div_vld[QuoW];
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
      s8_vld_q <= s7_vld_q;
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_qmag_q <= s4_qmag_d;
      s4_r_q    <= s4_r_d;
      s4_qneg_q <= div_stg[QuoW].neg;
      s4_ovf_q  <= div_stg[QuoW].ovf;

      s5_q_q    <= s5_q_d;
      s5_big_q  <= s4_ovf_q || (s4_qmag_q > QMagLim);
      s5_qneg_q <= s4_qneg_q;
      s5_ge_q   <= (s5_twice >= {1'b0, den_mag_q});
      s5_gt_q   <= (s5_twice >  {1'b0, den_mag_q});
      s5_rnz_q  <= (s4_r_q != '0);

      s6_n_q    <= s6_n_d;
      s6_big_q  <= s5_big_q;
      s6_qneg_q <= s5_qneg_q;
      s6_ge_q   <= s5_ge_q;
      s6_gt_q   <= s5_gt_q;
      s6_rnz_q  <= s5_rnz_q;

      s7_n_q    <= s7_n_d;
      s7_big_q  <= s6_big_q;
      s7_qneg_q <= s6_qneg_q;

      s8_res_q  <= s8_res_d;
      s8_sat_q  <= s8_sat_d;

      s9_res_q  <= s9_res_d;
      s9_sat_q  <= s9_sat_d;
      s9_sz_q   <= span_zero_q;
    end
  end

  // output register with one skid entry behind it
  assign take = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sk_vld_q  <= 1'b0;
    end else if (sk_vld_q) begin
      if (take) begin
        out_vld_q <= 1'b1;
        sk_vld_q  <= 1'b0;
      end
    end else if (!out_vld_q || take) begin
      out_vld_q <= s9_vld_q;
    end else if (s9_vld_q) begin
      sk_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_vld_q) begin
      if (take) begin
        out_cal_q <= sk_cal_q;
        out_sz_q  <= sk_sz_q;
        out_sat_q <= sk_sat_q;
      end
    end else if (!out_vld_q || take) begin
      out_cal_q <= s9_res_q;
      out_sz_q  <= s9_sz_q;
      out_sat_q <= s9_sat_q;
    end else begin
      sk_cal_q <= s9_res_q;
      sk_sz_q  <= s9_sz_q;
      sk_sat_q <= s9_sat_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign cal_value_o = out_cal_q;
  assign span_zero_o = out_sz_q;
  assign saturated_o = out_sat_q;

endmodule

// File: rtl/lrc_checker.sv
// Port-level checker for the linear range calibrator, bound to the top level.
module lrc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_i,
  input logic [lrc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input logic [lrc_pkg::DataW-1:0]         cfg_data_i,
  input logic                              out_valid_i,
  input logic                              out_stall_i,
  input logic signed [lrc_pkg::DataW-1:0]  cal_value_i,
  input logic                              span_zero_i,
  input logic                              saturated_i
);
  import lrc_pkg::*;

  logic clamp_q;

  // shadow of the clamp enable register, seen from the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_i && (cfg_index_i == RegClampEn)) begin
      clamp_q <= cfg_data_i[0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(cal_value_i))
    else $error("result changed while stalled");

  a_span_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && span_zero_i |-> (cal_value_i == '0) && !saturated_i)
    else $error("zero span result not forced to 0");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i && !clamp_q |-> (cal_value_i == ValMax) || (cal_value_i == ValMin))
    else $error("saturated result not at a 32-bit bound");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(span_zero_i && saturated_i))
    else $error("span_zero and saturated both set");

endmodule

bind linear_range_calibrator_unit lrc_checker u_lrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_i (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .cal_value_i (cal_value_o),
  .span_zero_i (span_zero_o),
  .saturated_i (saturated_o)
);

// File: dv/tb.sv
// Testbench for the linear range calibrator: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import lrc_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic signed [DataW-1:0] cal_value;
    logic                    span_zero;
    logic                    saturated;
  } cal_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DataW-1:0] raw_sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DataW-1:0] cal_value_o;
  logic span_zero_o;
  logic saturated_o;

  linear_range_calibrator_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .raw_sample_i (raw_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cal_value_o  (cal_value_o),
    .span_zero_o  (span_zero_o),
    .saturated_o  (saturated_o)
  );

  // local copy of the register file
  logic signed [DataW-1:0] cfg_raw_low  = RawLowRst;
  logic signed [DataW-1:0] cfg_raw_high = RawHighRst;
  logic signed [DataW-1:0] cfg_cal_low  = CalLowRst;
  logic signed [DataW-1:0] cfg_cal_high = CalHighRst;
  logic                    cfg_clamp_en = 1'b0;

  cal_res_t cal_expect_q[$];
  int unsigned fail_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit burst_mode = 1'b0;
  bit sending = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic bit [63:0] mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic cal_res_t predict_cal(logic signed [DataW-1:0] raw);
    cal_res_t res;
    longint a, b, den, n, lo, hi;
    bit [63:0] m, d, qm, rm, qmag, r;
    bit neg, qneg;
    res = '0;
    a   = longint'(raw) - longint'(cfg_raw_low);
    b   = longint'(cfg_cal_high) - longint'(cfg_cal_low);
    den = longint'(cfg_raw_high) - longint'(cfg_raw_low);
    if (den == 0) begin
      res.span_zero = 1'b1;
      return res;
    end
    m    = mag64(a) * mag64(b);
    d    = mag64(den);
    neg  = ((a < 0) != (b < 0)) != (den < 0);
    qm   = m / d;
    rm   = m % d;
    // floor division: remainder kept in [0, d)
    qneg = neg && (m != 0);
    qmag = (qneg && rm != 0) ? qm + 64'd1 : qm;
    r    = (qneg && rm != 0) ? d - rm : rm;
    if (qmag > (64'd1 << 34)) begin
      res.saturated = 1'b1;
      n = qneg ? longint'(ValMin) : longint'(ValMax);
    end else begin
      n = qneg ? -longint'(qmag) : longint'(qmag);
      n = n + longint'(cfg_cal_low);
      // round half away from zero on the fractional part r/d
      if (r != 0 && ((n >= 0) ? ((r << 1) >= d) : ((r << 1) > d)))
        n = n + 1;
      if (n > longint'(ValMax)) begin
        res.saturated = 1'b1;
        n = longint'(ValMax);
      end else if (n < longint'(ValMin)) begin
        res.saturated = 1'b1;
        n = longint'(ValMin);
      end
    end
    if (cfg_clamp_en) begin
      lo = longint'(cfg_cal_low);
      hi = longint'(cfg_cal_high);
      if (lo < hi) begin
        if (n < lo) n = lo;
        else if (n > hi) n = hi;
      end else begin
        if (n > lo) n = lo;
        else if (n < hi) n = hi;
      end
    end
    res.cal_value = n[DataW-1:0];
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    cal_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cal_expect_q.size() == 0) begin
        if (fail_cnt < 10)
          $display("unexpected item: cal_value=%0d span_zero=%0b saturated=%0b",
                   cal_value_o, span_zero_o, saturated_o);
        fail_cnt++;
      end else begin
        exp_res = cal_expect_q.pop_front();
        if (cal_value_o !== exp_res.cal_value || span_zero_o !== exp_res.span_zero ||
            saturated_o !== exp_res.saturated) begin
          if (fail_cnt < 10)
            $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                     exp_res.cal_value, exp_res.span_zero, exp_res.saturated,
                     cal_value_o, span_zero_o, saturated_o);
          fail_cnt++;
        end
      end
    end
  end

  // receiver stall, drawn per result
  initial begin
    int n;
    forever begin
      n = burst_mode ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(logic signed [DataW-1:0] raw);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      sending = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    sending = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cal_expect_q = {cal_expect_q, predict_cal(raw)};
  endtask

  task automatic wait_results_done();
    if (sending) begin
      in_valid_i <= 1'b0;
      sending = 1'b0;
    end
    while (cal_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (lrc_reg_e'(idx))
      RegRawLow:  cfg_raw_low  = data;
      RegRawHigh: cfg_raw_high = data;
      RegCalLow:  cfg_cal_low  = data;
      RegCalHigh: cfg_cal_high = data;
      RegClampEn: cfg_clamp_en = data[0];
      default: ;
    endcase
  endtask

  // only called with items in flight drained; always followed by items
  task automatic load_config(logic [DataW-1:0] rl, logic [DataW-1:0] rh,
                             logic [DataW-1:0] cl, logic [DataW-1:0] ch, bit ce);
    wait_results_done();
    if ($urandom_range(0, 3) == 0)
      write_reg(CfgIdxW'(int'(RegClampEn) + $urandom_range(1, 3)), $urandom());
    write_reg(RegRawLow, rl);
    write_reg(RegRawHigh, rh);
    write_reg(RegCalLow, cl);
    write_reg(RegCalHigh, ch);
    write_reg(RegClampEn, ($urandom() & ~32'h1) | {{(DataW-1){1'b0}}, ce});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: return $urandom_range(0, 2000) - 1000;
      3: begin
        case ($urandom_range(0, 4))
          0: return ValMin;
          1: return ValMax;
          2: return '0;
          3: return '1;
          default: return 1;
        endcase
      end
      4: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 20) - 10;
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] pick_sample();
    longint lo, hi, off;
    lo = longint'(cfg_raw_low);
    hi = longint'(cfg_raw_high);
    if (lo > hi) begin
      lo = longint'(cfg_raw_high);
      hi = longint'(cfg_raw_low);
    end
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return pick_word();
      2, 3: return cfg_raw_low + $urandom_range(0, 6) - 3;
      4: return cfg_raw_high + $urandom_range(0, 6) - 3;
      default: begin
        off = longint'({$urandom(), $urandom()} % (hi - lo + 1));
        return DataW'(lo + off);
      end
    endcase
  endfunction

  // register reset values map raw 0..65535 one to one
  task automatic test_defaults();
    send_sample(0);
    send_sample(65535);
    send_sample(32768);
    send_sample(-1);
  endtask

  task automatic test_zero_span();
    load_config(5, 5, -100, 100, 1'b1);
    send_sample(5);
    send_sample(-7);
  endtask

  // x2.5 scale puts exact halves on odd samples
  task automatic test_rounding();
    load_config(0, 4, 0, 10, 1'b0);
    send_sample(1);
    send_sample(-1);
    send_sample(3);
  endtask

  task automatic test_reversed_range();
    load_config(0, 10, 100, 0, 1'b1);
    send_sample(3);
    send_sample(-5);
    send_sample(20);
  endtask

  task automatic test_equal_bounds();
    load_config(0, 100, 50, 50, 1'b1);
    send_sample(7);
    send_sample(1000);
  endtask

  task automatic test_saturation();
    load_config(0, 1, ValMin, ValMax, 1'b1);
    send_sample(ValMax);
    send_sample(ValMin);
    send_sample(0);
    send_sample(1);
    load_config(ValMax, ValMin, ValMax, ValMin, 1'b0);
    send_sample(0);
    send_sample(ValMax);
    send_sample(ValMin);
    // small quotient, overflow only after adding cal_low
    load_config(0, 1, ValMax - 10, ValMax, 1'b0);
    send_sample(5);
  endtask

  // each phase drains fully before the next register set goes in
  task automatic test_random();
    logic [DataW-1:0] rl, rh, cl, ch;
    for (int phase = 0; phase < 30; phase++) begin
      rl = pick_word();
      rh = ($urandom_range(0, 7) == 0) ? rl : pick_word();
      cl = pick_word();
      ch = ($urandom_range(0, 7) == 0) ? cl : pick_word();
      load_config(rl, rh, cl, ch, 1'($urandom_range(0, 1)));
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 50; i++)
        send_sample(pick_sample());
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_zero_span();
    test_rounding();
    test_reversed_range();
    test_equal_bounds();
    test_saturation();
    test_random();
    wait_results_done();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && cal_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
